FILE: hdl/udiv_pkg.sv
// Package: shared types and constants for the pipelined unsigned divider.
`timescale 1ns / 1ps

package udiv_pkg;

  // Field width of every operand and result on the ports
  localparam int unsigned DATA_W = 64;

  // Default operand width used inside the datapath
  localparam int unsigned DEF_WIDTH = 64;

  // Operands of one division transaction
  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_in_t;

  // Result of one division transaction
  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              div_by_zero;
  } div_out_t;

  // Control bits that travel down the pipeline with the data
  typedef struct packed {
    logic valid;
    logic dz;
  } stg_ctrl_t;

endpackage : udiv_pkg

FILE: hdl/udiv_stage.sv
// One restoring division step with its pipeline register.
`timescale 1ns / 1ps

module udiv_stage #(
  parameter int unsigned WIDTH = udiv_pkg::DEF_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  udiv_pkg::stg_ctrl_t ctrl_i,
  input  logic [WIDTH-1:0]    n_i,
  input  logic [WIDTH-1:0]    d_i,
  input  logic [WIDTH-1:0]    q_i,
  input  logic [WIDTH-1:0]    r_i,
  output udiv_pkg::stg_ctrl_t ctrl_o,
  output logic [WIDTH-1:0]    n_o,
  output logic [WIDTH-1:0]    d_o,
  output logic [WIDTH-1:0]    q_o,
  output logic [WIDTH-1:0]    r_o
);

  logic [WIDTH:0]   full;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-1:0] n_d, q_d, r_d;

  logic [WIDTH-1:0]    n_q, d_q, q_q, r_q;
  udiv_pkg::stg_ctrl_t ctrl_q;

  // Shift the next dividend bit into the partial remainder, keeping the carry-out bit
  assign full = {r_i, n_i[WIDTH-1]};
  assign diff = full - {1'b0, d_i};
  assign ge   = ~diff[WIDTH];

  // Subtract when the remainder is not below the divisor and record the quotient bit
  always_comb begin
    n_d = {n_i[WIDTH-2:0], 1'b0};
    if (ge) begin
      r_d = diff[WIDTH-1:0];
      q_d = {q_i[WIDTH-2:0], 1'b1};
    end else begin
      r_d = full[WIDTH-1:0];
      q_d = {q_i[WIDTH-2:0], 1'b0};
    end
  end

  // Hold the control bits; they alone need reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance the datapath every cycle
  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= d_i;
    q_q <= q_d;
    r_q <= r_d;
  end

  assign ctrl_o = ctrl_q;
  assign n_o    = n_q;
  assign d_o    = d_q;
  assign q_o    = q_q;
  assign r_o    = r_q;

endmodule : udiv_stage

FILE: hdl/unsigned_divider_64_top.sv
// Top level: fully pipelined unsigned restoring divider.
//
//   channel  | handshake        | payload                  | direction
//   ---------+------------------+--------------------------+----------
//   operands | start_i, busy_o  | in_i  (udiv_pkg::div_in_t)  | in
//   result   | done_o (strobe)  | out_o (udiv_pkg::div_out_t) | out
//
// One pipeline stage per quotient bit: a transaction enters on any cycle with
// start_i high and its result shows on done_o once it has passed every stage.
// busy_o stays low, so one transaction per cycle is sustained.
// Reset clears only the stage control bits; no transaction is in flight after it.
// Results are shown for one cycle and are never held back.
`timescale 1ns / 1ps

module unsigned_divider_64_top #(
  parameter int unsigned WIDTH = udiv_pkg::DEF_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  udiv_pkg::div_in_t in_i,
  output logic              done_o,
  output udiv_pkg::div_out_t out_o
);

  udiv_pkg::stg_ctrl_t ctrl [0:WIDTH];
  logic [WIDTH-1:0]    n    [0:WIDTH];
  logic [WIDTH-1:0]    d    [0:WIDTH];
  logic [WIDTH-1:0]    q    [0:WIDTH];
  logic [WIDTH-1:0]    r    [0:WIDTH];

  // Feed the first stage from the ports; only the low WIDTH bits take part
  assign ctrl[0].valid = start_i;
  assign ctrl[0].dz    = (in_i.divisor[WIDTH-1:0] == '0);
  assign n[0]          = in_i.dividend[WIDTH-1:0];
  assign d[0]          = in_i.divisor[WIDTH-1:0];
  assign q[0]          = '0;
  assign r[0]          = '0;

  // Chain one division step per quotient bit
  for (genvar k = 0; k < WIDTH; k++) begin : g_stage
    udiv_stage #(
      .WIDTH(WIDTH)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[k]),
      .n_i    (n[k]),
      .d_i    (d[k]),
      .q_i    (q[k]),
      .r_i    (r[k]),
      .ctrl_o (ctrl[k+1]),
      .n_o    (n[k+1]),
      .d_o    (d[k+1]),
      .q_o    (q[k+1]),
      .r_o    (r[k+1])
    );
  end

  // Drive the result; a zero divisor forces both values to zero
  assign busy_o            = 1'b0;
  assign done_o            = ctrl[WIDTH].valid;
  assign out_o.quotient    = ctrl[WIDTH].dz ? '0 : udiv_pkg::DATA_W'(q[WIDTH]);
  assign out_o.remainder   = ctrl[WIDTH].dz ? '0 : udiv_pkg::DATA_W'(r[WIDTH]);
  assign out_o.div_by_zero = ctrl[WIDTH].dz;

  // The remainder of a finished division is below its divisor
  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ctrl[WIDTH].dz) |-> (r[WIDTH] < d[WIDTH]))
    else $error("remainder not below divisor");

  // The zero-divisor flag agrees with the divisor that reached the last stage
  a_dz_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_o.div_by_zero == (d[WIDTH] == '0)))
    else $error("div_by_zero flag does not match divisor");

  // A division by zero reports zero for both quotient and remainder
  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.div_by_zero) |->
      (out_o.quotient == '0 && out_o.remainder == '0))
    else $error("zero divisor gave a nonzero quotient or remainder");

endmodule : unsigned_divider_64_top
